FILE: rtl/mouse_delta_to_quadrature_core_macros.svh
// ----------------------------------------------------------------------------
// Mouse delta to quadrature: assertion macros
// Shared macros for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef MOUSE_DELTA_TO_QUADRATURE_CORE_MACROS_SVH
`define MOUSE_DELTA_TO_QUADRATURE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MDQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mdq check failed");

// Next-cycle implication, disabled while in reset.
`define MDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mdq check failed");

`endif

FILE: rtl/mdq_pkg.sv
// ----------------------------------------------------------------------------
// Mouse delta to quadrature: package
// Widths, register indexes and transaction types shared by the core.
// ----------------------------------------------------------------------------
package mdq_pkg;

    localparam int DELTA_BITS = 12;
    localparam int HOLD_W     = 12;
    localparam int GAIN_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam int SQ_W   = 2 * DELTA_BITS;
    localparam int SQ3_W  = SQ_W + 2;
    localparam int SUM_W  = DELTA_BITS + 1;
    localparam int RED_W  = SUM_W + GAIN_W;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 1'b1;

    localparam logic [HOLD_W-1:0] BASE_HOLD_RESET  = 12'd1200;
    localparam logic [GAIN_W-1:0] SPEED_GAIN_RESET = 4'd3;

    localparam logic [1:0] PH_A    = 2'd0;
    localparam logic [1:0] PH_AB   = 2'd1;
    localparam logic [1:0] PH_B    = 2'd2;
    localparam logic [1:0] PH_NONE = 2'd3;

    typedef struct packed {
        logic signed [DELTA_BITS-1:0] move_x;
        logic signed [DELTA_BITS-1:0] move_y;
        logic                         btn_left;
        logic                         btn_right;
        logic                         btn_middle;
    } t_in;

    typedef struct packed {
        logic              pin_up;
        logic              pin_down;
        logic              pin_left;
        logic              pin_right;
        logic [HOLD_W-1:0] hold_us;
        logic              out_left;
        logic              out_right;
        logic              out_middle;
        logic              last;
    } t_out;

    typedef struct packed {
        logic              btn_only;
        logic              move_x;
        logic              move_y;
        logic              neg_x;
        logic              neg_y;
        logic [HOLD_W-1:0] hold;
        logic [2:0]        btn;
    } t_cmd;

endpackage

FILE: rtl/mdq_front.sv
// ----------------------------------------------------------------------------
// Mouse delta to quadrature: front end
// Holds the configuration, classifies each report and builds one command.
// ----------------------------------------------------------------------------
module mdq_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [mdq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mdq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  mdq_pkg::t_in                     i_in,
    input  logic                             i_accept,
    output logic                             o_cmd_valid,
    output mdq_pkg::t_cmd                    o_cmd
);

    logic [mdq_pkg::HOLD_W-1:0]     r_base_hold;
    logic [mdq_pkg::GAIN_W-1:0]     r_speed_gain;
    logic [2:0]                     r_prev_btn;

    logic [2:0]                     btn;
    logic                           zero_x;
    logic                           zero_y;
    logic [mdq_pkg::DELTA_BITS-1:0] abs_x;
    logic [mdq_pkg::DELTA_BITS-1:0] abs_y;
    logic [mdq_pkg::SQ_W-1:0]       sq_x;
    logic [mdq_pkg::SQ_W-1:0]       sq_y;
    logic [mdq_pkg::SQ3_W-1:0]      sq3_x;
    logic [mdq_pkg::SQ3_W-1:0]      sq3_y;
    logic [mdq_pkg::SUM_W-1:0]      abs_sum;
    logic [mdq_pkg::RED_W-1:0]      red;
    logic [mdq_pkg::RED_W-1:0]      base_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_hold  <= mdq_pkg::BASE_HOLD_RESET;
            r_speed_gain <= mdq_pkg::SPEED_GAIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mdq_pkg::CFG_BASE_HOLD:  r_base_hold  <= i_cfg_data[mdq_pkg::HOLD_W-1:0];
                mdq_pkg::CFG_SPEED_GAIN: r_speed_gain <= i_cfg_data[mdq_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn <= 3'b000;
        end else if (i_accept) begin
            r_prev_btn <= btn;
        end
    end

    always_comb begin
        btn      = {i_in.btn_middle, i_in.btn_right, i_in.btn_left};
        zero_x   = (i_in.move_x == '0);
        zero_y   = (i_in.move_y == '0);
        abs_x    = i_in.move_x[mdq_pkg::DELTA_BITS-1] ? (~i_in.move_x + 1'b1) : i_in.move_x;
        abs_y    = i_in.move_y[mdq_pkg::DELTA_BITS-1] ? (~i_in.move_y + 1'b1) : i_in.move_y;
        sq_x     = mdq_pkg::SQ_W'(abs_x) * mdq_pkg::SQ_W'(abs_x);
        sq_y     = mdq_pkg::SQ_W'(abs_y) * mdq_pkg::SQ_W'(abs_y);
        sq3_x    = mdq_pkg::SQ3_W'(sq_x) + (mdq_pkg::SQ3_W'(sq_x) << 1);
        sq3_y    = mdq_pkg::SQ3_W'(sq_y) + (mdq_pkg::SQ3_W'(sq_y) << 1);
        abs_sum  = mdq_pkg::SUM_W'(abs_x) + mdq_pkg::SUM_W'(abs_y);
        red      = mdq_pkg::RED_W'(r_speed_gain) * mdq_pkg::RED_W'(abs_sum);
        base_ext = mdq_pkg::RED_W'(r_base_hold);

        o_cmd.btn_only = zero_x && zero_y;
        o_cmd.move_x   = !zero_x && (mdq_pkg::SQ3_W'(sq_y) < sq3_x);
        o_cmd.move_y   = !zero_y && (mdq_pkg::SQ3_W'(sq_x) < sq3_y);
        o_cmd.neg_x    = i_in.move_x[mdq_pkg::DELTA_BITS-1];
        o_cmd.neg_y    = i_in.move_y[mdq_pkg::DELTA_BITS-1];
        o_cmd.hold     = (red >= base_ext) ? '0
                                           : mdq_pkg::HOLD_W'(base_ext - red);
        o_cmd.btn      = btn;

        o_cmd_valid = i_accept && (!(zero_x && zero_y) || (btn != r_prev_btn));
    end

endmodule

FILE: rtl/mdq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Mouse delta to quadrature: command queue
// Short queue that decouples the front end from the phase sequencer.
// ----------------------------------------------------------------------------
module mdq_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mdq_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output mdq_pkg::t_cmd o_head
);

    mdq_pkg::t_cmd                r_mem [mdq_pkg::CMDQ_DEPTH];
    logic [mdq_pkg::CMDQ_AW-1:0]  r_wr_ptr;
    logic [mdq_pkg::CMDQ_AW-1:0]  r_rd_ptr;
    logic [mdq_pkg::CMDQ_CW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == mdq_pkg::CMDQ_CW'(mdq_pkg::CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mdq_back.sv
// ----------------------------------------------------------------------------
// Mouse delta to quadrature: phase sequencer
// Steps through the quadrature phases of each command into an output register.
// ----------------------------------------------------------------------------
module mdq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  mdq_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output mdq_pkg::t_out o_out
);

    logic          r_out_valid;
    mdq_pkg::t_out r_out;
    logic [1:0]    r_phase;
    logic          r_on_x;

    logic          emit;
    logic          on_y;
    logic          line_a;
    logic          line_b;
    logic          a_is_first;
    logic          last;
    mdq_pkg::t_out n_out;

    always_comb begin
        on_y = i_cmd.move_y && !r_on_x;
        unique case (r_phase)
            mdq_pkg::PH_A:    begin line_a = 1'b1; line_b = 1'b0; end
            mdq_pkg::PH_AB:   begin line_a = 1'b1; line_b = 1'b1; end
            mdq_pkg::PH_B:    begin line_a = 1'b0; line_b = 1'b1; end
            mdq_pkg::PH_NONE: begin line_a = 1'b0; line_b = 1'b0; end
            default:          begin line_a = 1'b0; line_b = 1'b0; end
        endcase
        a_is_first = on_y ? i_cmd.neg_y : i_cmd.neg_x;
        last = i_cmd.btn_only
            || ((r_phase == mdq_pkg::PH_NONE) && (!on_y || !i_cmd.move_x));

        n_out.pin_up     = 1'b0;
        n_out.pin_down   = 1'b0;
        n_out.pin_left   = 1'b0;
        n_out.pin_right  = 1'b0;
        if (!i_cmd.btn_only) begin
            if (on_y) begin
                n_out.pin_left  = a_is_first ? line_a : line_b;
                n_out.pin_right = a_is_first ? line_b : line_a;
            end else begin
                n_out.pin_up    = a_is_first ? line_a : line_b;
                n_out.pin_down  = a_is_first ? line_b : line_a;
            end
        end
        n_out.hold_us    = i_cmd.btn_only ? '0 : i_cmd.hold;
        n_out.out_left   = i_cmd.btn[0];
        n_out.out_right  = i_cmd.btn[1];
        n_out.out_middle = i_cmd.btn[2];
        n_out.last       = last;
    end

    assign emit      = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = emit && last;
    assign o_empty   = !r_out_valid;
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= mdq_pkg::PH_A;
            r_on_x      <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                if (last) begin
                    r_phase <= mdq_pkg::PH_A;
                    r_on_x  <= 1'b0;
                end else begin
                    r_phase <= r_phase + 1'b1;
                    if (r_phase == mdq_pkg::PH_NONE) begin
                        r_on_x <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/mouse_delta_to_quadrature_core.sv
// ----------------------------------------------------------------------------
// Mouse delta to quadrature: top level
// Turns mouse reports into quadrature line phases with hold times.
// ----------------------------------------------------------------------------
// A report is classified in the cycle it is accepted and lands as one command
// in a four-entry queue; the front end keeps accepting reports until that
// queue is full. The phase sequencer emits one result per cycle into an
// output register while that register is empty or being popped, so a report
// yields four results when one axis moves, eight when both move and one for a
// button-only update; a report with no motion and unchanged buttons yields
// nothing. The first result of a report passes through the queue and then the
// output register before it reaches the result ports. Configuration writes are
// always ready and take effect for the next accepted report.
module mouse_delta_to_quadrature_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mdq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mdq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  mdq_pkg::t_in                    i_in,
    output logic                            empty,
    input  logic                            pop,
    output mdq_pkg::t_out                   o_out
);

    logic          accept;
    logic          cmd_push;
    mdq_pkg::t_cmd cmd_in;
    logic          cmd_valid;
    mdq_pkg::t_cmd cmd_head;
    logic          cmd_pop;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    mdq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_accept    (accept),
        .o_cmd_valid (cmd_push),
        .o_cmd       (cmd_in)
    );

    mdq_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_head  (cmd_head)
    );

    mdq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/mdq_checker.sv
// ----------------------------------------------------------------------------
// Mouse delta to quadrature: port checker
// Concurrent checks on the core's ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "mouse_delta_to_quadrature_core_macros.svh"

module mdq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          empty,
    input logic          pop,
    input mdq_pkg::t_out o_out
);

    // A waiting result is not withdrawn or changed until it is taken.
    `MDQ_ASSERT_NEXT(a_out_held, !empty && !pop, !empty && $stable(o_out))

    // A phase drives the lines of one axis only.
    `MDQ_ASSERT_NOW(a_one_axis, !empty,
        !((o_out.pin_up || o_out.pin_down) && (o_out.pin_left || o_out.pin_right)))

    // The final result of a report always has every line low.
    `MDQ_ASSERT_NOW(a_last_idle, !empty && o_out.last,
        !(o_out.pin_up || o_out.pin_down || o_out.pin_left || o_out.pin_right))

    // Once a report has started, its next result follows without a gap.
    `MDQ_ASSERT_NEXT(a_no_gap, !empty && pop && !o_out.last, !empty)

endmodule

bind mouse_delta_to_quadrature_core mdq_checker u_mdq_checker (.*);
